FILE: rtl/core/nsbd_pkg.sv
package nsbd_pkg;

	// Width of the signed Q16.16 input fields.
	localparam int VALUE_WIDTH = 32;
	// Exact differences of two values, and the negated step, fit in two more bits.
	localparam int DIFF_W = VALUE_WIDTH + 2;
	// Divider remainder and divisor magnitudes (divisor is at most 2^VALUE_WIDTH).
	localparam int REM_W = VALUE_WIDTH + 1;
	// Fraction bits of the damping factor and quotient bits of the divider.
	localparam int FRAC_BITS = 16;
	localparam int CNT_W = $clog2(FRAC_BITS);
	// Damping factor in unsigned Q1.16.
	localparam int DAMP_W = FRAC_BITS + 1;
	localparam logic [DAMP_W-1:0] DAMP_ONE = DAMP_W'(1) << FRAC_BITS;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic calc;
		logic decide;
		logic div_step;
		logic update;
	} nsbd_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_div;
		logic last;
		logic out_blocked;
	} nsbd_sts_t;

endpackage

FILE: rtl/core/nsbd_ctrl.sv
module nsbd_ctrl import nsbd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  nsbd_sts_t sts,
	output nsbd_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIFF,
		S_DECIDE,
		S_DIV,
		S_UPDATE
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             finish;

	// The final step waits while an earlier result still sits in the output register.
	assign finish = !(sts.last && sts.out_blocked);

	// Input is taken only between items.
	assign in_stall = (state_q != S_IDLE);

	// Commands decode straight from the state.
	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE:   cmd.load = in_valid;
			S_DIFF:   cmd.calc = 1'b1;
			S_DECIDE: cmd.decide = 1'b1;
			S_DIV:    cmd.div_step = 1'b1;
			S_UPDATE: cmd.update = finish;
			default:  cmd = '0;
		endcase
	end

	// State sequence and the divider iteration counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DIFF;
					end
				end
				S_DIFF: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					cnt_q   <= '0;
					state_q <= sts.need_div ? S_DIV : S_UPDATE;
				end
				S_DIV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(FRAC_BITS - 1)) begin
						state_q <= S_UPDATE;
					end
				end
				S_UPDATE: begin
					if (finish) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/core/nsbd_datapath.sv
module nsbd_datapath import nsbd_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  nsbd_cmd_t                     cmd,
	output nsbd_sts_t                     sts,
	input  logic signed [VALUE_WIDTH-1:0] cur_value,
	input  logic signed [VALUE_WIDTH-1:0] step_value,
	input  logic signed [VALUE_WIDTH-1:0] lower_bound,
	input  logic signed [VALUE_WIDTH-1:0] upper_bound,
	input  logic                          last_item,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [DAMP_W-1:0]             damping
);

	logic signed [VALUE_WIDTH-1:0] val_q, step_q, lo_q, hi_q;
	logic                          last_q;
	logic signed [DIFF_W-1:0]      num_up_q, num_lo_q, den_up_q, den_lo_q;
	logic                          apply_q;
	logic [REM_W-1:0]              rem_q, dsr_q;
	logic [FRAC_BITS-1:0]          ratio_q;
	logic [DAMP_W-1:0]             factor_q;
	logic                          out_valid_q;
	logic [DAMP_W-1:0]             damping_q;

	logic                     up_hit, lo_hit, hit;
	logic signed [DIFF_W-1:0] sel_num, sel_den;
	logic                     num_neg, num_zero, den_neg;
	logic                     apply, need_div;
	logic [REM_W:0]           rem2;
	logic                     ge;
	logic [REM_W:0]           rem_sub;
	logic [DAMP_W-1:0]        factor_new;

	// Bound tests on the registered differences; the upper bound takes precedence.
	assign up_hit   = den_up_q > num_up_q;
	assign lo_hit   = den_lo_q > num_lo_q;
	assign hit      = up_hit || lo_hit;
	assign sel_num  = up_hit ? num_up_q : num_lo_q;
	assign sel_den  = up_hit ? den_up_q : den_lo_q;
	assign num_neg  = sel_num[DIFF_W-1];
	assign num_zero = (sel_num == '0);
	assign den_neg  = sel_den[DIFF_W-1];

	// A negative numerator with a negative denominator means a ratio above one.
	assign apply    = hit && !(num_neg && den_neg);
	assign need_div = hit && !num_neg && !num_zero;

	// One restoring division step per cycle.
	assign rem2    = {rem_q, 1'b0};
	assign ge      = rem2 >= {1'b0, dsr_q};
	assign rem_sub = rem2 - {1'b0, dsr_q};

	// Running minimum; the restart at the end of a step is in the register update below.
	assign factor_new = (apply_q && (DAMP_W'(ratio_q) < factor_q)) ? DAMP_W'(ratio_q) : factor_q;

	assign sts.need_div    = need_div;
	assign sts.last        = last_q;
	assign sts.out_blocked = out_valid_q && out_stall;

	assign out_valid = out_valid_q;
	assign damping   = damping_q;

	// Item registers, differences, divider state and the output value.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q  <= cur_value;
			step_q <= step_value;
			lo_q   <= lower_bound;
			hi_q   <= upper_bound;
			last_q <= last_item;
		end
		if (cmd.calc) begin
			num_up_q <= DIFF_W'(hi_q) - DIFF_W'(val_q);
			num_lo_q <= DIFF_W'(val_q) - DIFF_W'(lo_q);
			den_up_q <= DIFF_W'(step_q);
			den_lo_q <= -DIFF_W'(step_q);
		end
		if (cmd.decide) begin
			apply_q <= apply;
			ratio_q <= '0;
			rem_q   <= sel_num[REM_W-1:0];
			dsr_q   <= sel_den[REM_W-1:0];
		end
		if (cmd.div_step) begin
			rem_q   <= ge ? rem_sub[REM_W-1:0] : rem2[REM_W-1:0];
			ratio_q <= {ratio_q[FRAC_BITS-2:0], ge};
		end
		if (cmd.update && last_q) begin
			damping_q <= factor_new;
		end
	end

	// Damping factor and the output register's valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q    <= DAMP_ONE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.update && last_q) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.update) begin
				if (last_q) begin
					factor_q <= DAMP_ONE;
				end else begin
					factor_q <= factor_new;
				end
			end
		end
	end

endmodule

FILE: rtl/core/newton_step_bound_damping.sv
// Damping factor for one Newton step. Each input transfer carries one solution element
// (value, step, lower and upper bound, signed Q16.16) and a last flag. The block keeps
// the least ratio that keeps value plus damped step inside its bounds, starting at 1.0,
// and on the last element sends the factor (unsigned Q1.16, 65536 is 1.0) as one output
// transfer and restarts at 1.0. An element passes the difference and decision states,
// the restoring divider (one quotient bit per cycle) unless it is in bounds or its ratio
// is zero or above one, and the update state. Input is stalled while an element is in
// work; the output register lets the next step's elements enter while a result waits to
// be taken, and a last element holds in its update state until it is.
module newton_step_bound_damping import nsbd_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [VALUE_WIDTH-1:0] cur_value,
	input  logic signed [VALUE_WIDTH-1:0] step_value,
	input  logic signed [VALUE_WIDTH-1:0] lower_bound,
	input  logic signed [VALUE_WIDTH-1:0] upper_bound,
	input  logic                          last_item,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [DAMP_W-1:0]             damping
);

	nsbd_cmd_t cmd;
	nsbd_sts_t sts;

	// Sequencer.
	nsbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Differences, divider, running minimum and output register.
	nsbd_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cur_value   (cur_value),
		.step_value  (step_value),
		.lower_bound (lower_bound),
		.upper_bound (upper_bound),
		.last_item   (last_item),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.damping     (damping)
	);

endmodule

FILE: test/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import nsbd_pkg::*;

	localparam int DRAIN_CYCLES = 40;
	localparam int STALL_LIMIT = 5000;
	localparam logic signed [VALUE_WIDTH-1:0] Q_ONE = 1 <<< FRAC_BITS;
	localparam logic signed [VALUE_WIDTH-1:0] V_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
	localparam logic signed [VALUE_WIDTH-1:0] V_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_stall;
	logic signed [VALUE_WIDTH-1:0] cur_value;
	logic signed [VALUE_WIDTH-1:0] step_value;
	logic signed [VALUE_WIDTH-1:0] lower_bound;
	logic signed [VALUE_WIDTH-1:0] upper_bound;
	logic                          last_item;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [DAMP_W-1:0]             damping;

	// Running damping factor of the current Newton step, as the block should hold it.
	logic [DAMP_W-1:0] running_factor;
	logic [DAMP_W-1:0] expected_damping[$];

	int send_idle_pct;
	int recv_idle_pct;
	int hold_left;
	int quiet_cycles;
	int errors;
	int sent_count;
	int checked_count;
	int below_one_count;

	newton_step_bound_damping u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cur_value   (cur_value),
		.step_value  (step_value),
		.lower_bound (lower_bound),
		.upper_bound (upper_bound),
		.last_item   (last_item),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.damping     (damping)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The new factor after one bound: the lesser of the old factor and num/den in Q1.16.
	// The caller guarantees den > num.
	function automatic logic [DAMP_W-1:0] limit_factor(input logic signed [DIFF_W-1:0] num,
			input logic signed [DIFF_W-1:0] den, input logic [DAMP_W-1:0] factor);
		logic [DIFF_W+FRAC_BITS-1:0] dividend;
		logic [DIFF_W+FRAC_BITS-1:0] quotient;
		logic [DAMP_W-1:0]           ratio;
		if (num < 0) begin
			// Both negative means the ratio is above one, so nothing changes.
			if (den < 0) return factor;
			ratio = '0;
		end else if (num == 0) begin
			ratio = '0;
		end else begin
			dividend = {num, {FRAC_BITS{1'b0}}};
			quotient = dividend / (DIFF_W+FRAC_BITS)'(den);
			ratio = quotient[DAMP_W-1:0];
		end
		return (ratio < factor) ? ratio : factor;
	endfunction

	// Update the running factor for one accepted element and queue the factor on the last one.
	function automatic void track_element(input logic signed [VALUE_WIDTH-1:0] val,
			input logic signed [VALUE_WIDTH-1:0] stp, input logic signed [VALUE_WIDTH-1:0] lo,
			input logic signed [VALUE_WIDTH-1:0] hi, input logic last);
		logic signed [DIFF_W-1:0] v;
		logic signed [DIFF_W-1:0] s;
		logic signed [DIFF_W-1:0] l;
		logic signed [DIFF_W-1:0] h;
		v = val;
		s = stp;
		l = lo;
		h = hi;
		// The upper bound wins when both are crossed.
		if (s > h - v)
			running_factor = limit_factor(h - v, s, running_factor);
		else if (-s > v - l)
			running_factor = limit_factor(v - l, -s, running_factor);
		if (last) begin
			expected_damping.push_back(running_factor);
			if (running_factor < DAMP_ONE) below_one_count++;
			running_factor = DAMP_ONE;
		end
	endfunction

	// Offer one element, hold it until the transfer, then predict its effect.
	task automatic send_element(input logic signed [VALUE_WIDTH-1:0] val,
			input logic signed [VALUE_WIDTH-1:0] stp, input logic signed [VALUE_WIDTH-1:0] lo,
			input logic signed [VALUE_WIDTH-1:0] hi, input logic last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		cur_value = val;
		step_value = stp;
		lower_bound = lo;
		upper_bound = hi;
		last_item = last;
		do
			@(posedge clk);
		while (in_stall);
		track_element(val, stp, lo, hi, last);
		sent_count++;
		@(negedge clk);
	endtask

	// Stop offering and wait until every expected factor has come out, then let the block settle.
	task automatic drain;
		in_valid = 1'b0;
		while (expected_damping.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic signed [VALUE_WIDTH-1:0] pick_corner();
		case ($urandom_range(0, 6))
			0: return V_MIN;
			1: return V_MAX;
			2: return '0;
			3: return -1;
			4: return 1;
			5: return Q_ONE;
			default: return -Q_ONE;
		endcase
	endfunction

	// Mostly elements near a sane box with a step of random size, plus corner values and noise.
	task automatic make_element(output logic signed [VALUE_WIDTH-1:0] val,
			output logic signed [VALUE_WIDTH-1:0] stp, output logic signed [VALUE_WIDTH-1:0] lo,
			output logic signed [VALUE_WIDTH-1:0] hi);
		int kind;
		int center;
		int mag;
		logic signed [VALUE_WIDTH-1:0] swap;
		kind = $urandom_range(0, 99);
		if (kind < 15) begin
			val = $urandom;
			stp = $urandom;
			lo = $urandom;
			hi = $urandom;
		end else if (kind < 25) begin
			val = pick_corner();
			stp = pick_corner();
			lo = pick_corner();
			hi = pick_corner();
		end else begin
			center = int'($urandom_range(0, 1 << 29)) - (1 << 28);
			lo = center - int'($urandom_range(0, 1 << 21));
			hi = center + int'($urandom_range(0, 1 << 21));
			val = lo + int'($urandom_range(0, hi - lo));
			if ($urandom_range(0, 9) == 0)
				val = $urandom_range(0, 1) ? hi + int'($urandom_range(0, 1 << 16))
						: lo - int'($urandom_range(0, 1 << 16));
			mag = int'($urandom_range(0, 1 << $urandom_range(4, 23)));
			stp = $urandom_range(0, 1) ? mag : -mag;
			if ($urandom_range(0, 19) == 0) begin
				swap = lo;
				lo = hi;
				hi = swap;
			end
		end
	endtask

	// Steps that stay inside the box leave the factor at 1.0.
	task automatic test_in_bounds;
		send_element('0, Q_ONE / 2, -Q_ONE, Q_ONE, 1'b0);
		send_element(Q_ONE, '0, -Q_ONE, Q_ONE, 1'b1);
	endtask

	// Crossing the upper bound, including a quotient that truncates.
	task automatic test_upper_crossing;
		send_element('0, 2 * Q_ONE, -4 * Q_ONE, Q_ONE, 1'b0);
		send_element('0, 3, -1, 1, 1'b1);
		// A step that lands exactly on the bound does not cross it.
		send_element('0, Q_ONE, -Q_ONE, Q_ONE, 1'b1);
	endtask

	// Crossing the lower bound, including a value that sits on the bound.
	task automatic test_lower_crossing;
		send_element('0, -4 * Q_ONE, -Q_ONE, 4 * Q_ONE, 1'b1);
		send_element(-Q_ONE, -1, -Q_ONE, Q_ONE, 1'b1);
	endtask

	task automatic test_special_cases;
		// Value and new value both beyond the upper bound: ratio above one.
		send_element(10 * Q_ONE, -2 * Q_ONE, '0, 5 * Q_ONE, 1'b1);
		// Out of bounds and moving further out: the factor drops to zero.
		send_element(6 * Q_ONE, Q_ONE, '0, 5 * Q_ONE, 1'b1);
		// Zero step on a value above, then below, the box.
		send_element(6 * Q_ONE, '0, '0, 5 * Q_ONE, 1'b1);
		send_element(-Q_ONE, '0, '0, 5 * Q_ONE, 1'b1);
		// Crossed bounds: a step up hits the upper test, a step down the lower one.
		send_element('0, 2 * Q_ONE, 4 * Q_ONE, Q_ONE, 1'b1);
		send_element('0, -2 * Q_ONE, 4 * Q_ONE, Q_ONE, 1'b1);
	endtask

	task automatic test_extremes;
		send_element(V_MIN, V_MAX, V_MIN, V_MAX, 1'b0);
		send_element(V_MAX, V_MAX, V_MIN, V_MIN, 1'b1);
		send_element(V_MIN, V_MIN, V_MAX, V_MAX, 1'b1);
		send_element(V_MIN, V_MAX, V_MIN, -1, 1'b1);
		send_element(V_MIN, V_MAX, V_MIN, -2, 1'b1);
		send_element('0, V_MAX, V_MIN, 1, 1'b0);
		send_element('0, V_MIN, -1, V_MAX, 1'b1);
	endtask

	// The receiver holds off for a long stretch while elements keep coming, so the block
	// fills and stalls its input; then the sender pauses until everything has drained.
	task automatic test_output_hold_off;
		logic signed [VALUE_WIDTH-1:0] val;
		logic signed [VALUE_WIDTH-1:0] stp;
		logic signed [VALUE_WIDTH-1:0] lo;
		logic signed [VALUE_WIDTH-1:0] hi;
		send_idle_pct = 0;
		hold_left = 300;
		repeat (8) begin
			make_element(val, stp, lo, hi);
			send_element(val, stp, lo, hi, 1'b1);
		end
		drain();
	endtask

	// Random Newton steps of one to eight elements, the last one marked.
	task automatic test_random(input int count, input int s_pct, input int r_pct);
		logic signed [VALUE_WIDTH-1:0] val;
		logic signed [VALUE_WIDTH-1:0] stp;
		logic signed [VALUE_WIDTH-1:0] lo;
		logic signed [VALUE_WIDTH-1:0] hi;
		int group_len;
		int done;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		done = 0;
		while (done < count) begin
			group_len = $urandom_range(1, 8);
			for (int i = 0; i < group_len; i++) begin
				make_element(val, stp, lo, hi);
				send_element(val, stp, lo, hi, i == group_len - 1);
			end
			done += group_len;
		end
		drain();
	endtask

	// Receiver stall: a requested hold-off first, otherwise random at the current rate.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall = 1'b1;
			hold_left--;
		end else begin
			out_stall = ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// Compare every output transfer with the oldest expected factor.
	always @(posedge clk) begin : check_damping
		logic [DAMP_W-1:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_damping.size() == 0) begin
				$display("%0t: unexpected damping transfer, expected none, actual %0d",
						$time, damping);
				errors++;
			end else begin
				want = expected_damping.pop_front();
				checked_count++;
				if (damping !== want) begin
					$display("%0t: damping mismatch, expected %0d, actual %0d",
							$time, want, damping);
					errors++;
				end
			end
		end
	end

	// End the run when no transfer happens on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles, %0d factors outstanding",
					$time, quiet_cycles, expected_damping.size());
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		cur_value = '0;
		step_value = '0;
		lower_bound = '0;
		upper_bound = '0;
		last_item = 1'b0;
		running_factor = DAMP_ONE;
		send_idle_pct = 13;
		recv_idle_pct = 53;
		hold_left = 0;
		quiet_cycles = 0;
		errors = 0;
		sent_count = 0;
		checked_count = 0;
		below_one_count = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_in_bounds();
		test_upper_crossing();
		test_lower_crossing();
		test_special_cases();
		test_extremes();
		drain();
		test_output_hold_off();
		test_random(380, 13, 53);
		test_random(380, 53, 13);
		test_random(380, 0, 0);

		$display("Sent %0d elements: directed bound cases, an output hold-off, random steps.",
				sent_count);
		$display("Checked %0d damping factors, %0d of them below 1.0.",
				checked_count, below_one_count);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
